// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, expr) \
	label: assert property (@(posedge clk) (expr)) \
		else $error("assertion failed: invariant");

`endif

// File: rtl/tfd_pkg.sv
// ----------------------------------------------------------------------------
// tfd_pkg
// Types, constants and helpers for the tank fill and drain sequencer.
// ----------------------------------------------------------------------------
package tfd_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int CFG_W       = 16;
	localparam int CMP_W       = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

	typedef logic [TIMER_WIDTH-1:0] timer_t;
	localparam timer_t TIMER_MAX = {TIMER_WIDTH{1'b1}};

	typedef enum logic [1:0] {
		REG_AUTO_REFILL = 2'd0,
		REG_DRAIN_LIMIT = 2'd1,
		REG_DRAIN_WAIT  = 2'd2
	} reg_idx_t;

	localparam logic              RST_AUTO_REFILL = 1'b1;
	localparam logic [CFG_W-1:0]  RST_DRAIN_LIMIT = 16'd600;
	localparam logic [CFG_W-1:0]  RST_DRAIN_WAIT  = 16'd3600;

	typedef enum logic [5:0] {
		FP_IDLE       = 6'b000001,
		FP_FIRST      = 6'b000010,
		FP_END_FIRST  = 6'b000100,
		FP_SECOND     = 6'b001000,
		FP_END_SECOND = 6'b010000,
		FP_DONE       = 6'b100000
	} fill_phase_t;

	typedef enum logic [4:0] {
		DP_IDLE  = 5'b00001,
		DP_START = 5'b00010,
		DP_DRAIN = 5'b00100,
		DP_END   = 5'b01000,
		DP_WAIT  = 5'b10000
	} drain_phase_t;

	localparam logic [2:0] FC_IDLE       = 3'd0;
	localparam logic [2:0] FC_FIRST      = 3'd1;
	localparam logic [2:0] FC_END_FIRST  = 3'd2;
	localparam logic [2:0] FC_SECOND     = 3'd3;
	localparam logic [2:0] FC_END_SECOND = 3'd4;
	localparam logic [2:0] FC_DONE       = 3'd5;

	localparam logic [2:0] DC_IDLE  = 3'd0;
	localparam logic [2:0] DC_START = 3'd1;
	localparam logic [2:0] DC_DRAIN = 3'd2;
	localparam logic [2:0] DC_END   = 3'd3;
	localparam logic [2:0] DC_WAIT  = 3'd4;

	typedef struct packed {
		logic             auto_refill;
		logic [CFG_W-1:0] drain_time_limit;
		logic [CFG_W-1:0] drain_wait_time;
	} cfg_t;

	typedef struct packed {
		logic empty;
		logic middle;
		logic full;
	} levels_t;

	typedef struct packed {
		fill_phase_t phase;
		logic        valve;
		logic        pump2;
	} fill_st_t;

	typedef struct packed {
		drain_phase_t phase;
		timer_t       on_timer;
		timer_t       wait_timer;
		logic         pump;
	} drain_st_t;

	function automatic timer_t sat_inc(timer_t t);
		return (t == TIMER_MAX) ? TIMER_MAX : t + timer_t'(1);
	endfunction

	function automatic logic [2:0] fill_code(fill_phase_t p);
		logic [2:0] c;
		unique case (p)
			FP_IDLE:       c = FC_IDLE;
			FP_FIRST:      c = FC_FIRST;
			FP_END_FIRST:  c = FC_END_FIRST;
			FP_SECOND:     c = FC_SECOND;
			FP_END_SECOND: c = FC_END_SECOND;
			FP_DONE:       c = FC_DONE;
			default:       c = FC_IDLE;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] drain_code(drain_phase_t p);
		logic [2:0] c;
		unique case (p)
			DP_IDLE:  c = DC_IDLE;
			DP_START: c = DC_START;
			DP_DRAIN: c = DC_DRAIN;
			DP_END:   c = DC_END;
			DP_WAIT:  c = DC_WAIT;
			default:  c = DC_IDLE;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/tfd_if.sv
// ----------------------------------------------------------------------------
// tfd_if
// Valid/ready channels: sensor items, result items and register writes.
// ----------------------------------------------------------------------------
interface tfd_in_if;
	logic valid;
	logic ready;
	logic level_empty;
	logic level_middle;
	logic level_full;

	modport source (output valid, level_empty, level_middle, level_full, input ready);
	modport sink   (input valid, level_empty, level_middle, level_full, output ready);
endinterface

interface tfd_out_if;
	logic       valid;
	logic       ready;
	logic       first_valve_on;
	logic       second_pump_on;
	logic       drain_pump_on;
	logic [2:0] fill_phase_out;
	logic [2:0] drain_phase_out;

	modport source (output valid, first_valve_on, second_pump_on, drain_pump_on,
		fill_phase_out, drain_phase_out, input ready);
	modport sink   (input valid, first_valve_on, second_pump_on, drain_pump_on,
		fill_phase_out, drain_phase_out, output ready);
endinterface

interface tfd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/tfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// tfd_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module tfd_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	tfd_cfg_if.sink       cfg,
	output tfd_pkg::cfg_t regs
);
	import tfd_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.auto_refill      <= RST_AUTO_REFILL;
			regs_q.drain_time_limit <= RST_DRAIN_LIMIT;
			regs_q.drain_wait_time  <= RST_DRAIN_WAIT;
		end else if (cfg.valid) begin
			if (cfg.index == REG_AUTO_REFILL) begin
				regs_q.auto_refill <= cfg.data[0];
			end
			if (cfg.index == REG_DRAIN_LIMIT) begin
				regs_q.drain_time_limit <= cfg.data;
			end
			if (cfg.index == REG_DRAIN_WAIT) begin
				regs_q.drain_wait_time <= cfg.data;
			end
		end
	end

endmodule

// File: rtl/tfd_fill_step.sv
// ----------------------------------------------------------------------------
// tfd_fill_step
// Next fill phase and fill actuator levels for one tick.
// ----------------------------------------------------------------------------
module tfd_fill_step (
	input  logic              auto_refill,
	input  tfd_pkg::levels_t  lvl,
	input  tfd_pkg::fill_st_t cur,
	output tfd_pkg::fill_st_t nxt
);
	import tfd_pkg::*;

	fill_phase_t np;

	always_comb begin
		np = cur.phase;
		unique case (cur.phase)
			FP_IDLE:       if (lvl.empty && !lvl.middle && !lvl.full) np = FP_FIRST;
			FP_FIRST:      if (lvl.middle) np = FP_END_FIRST;
			FP_END_FIRST:  np = FP_SECOND;
			FP_SECOND:     if (lvl.full) np = FP_END_SECOND;
			FP_END_SECOND: np = auto_refill ? FP_IDLE : FP_DONE;
			default:       np = cur.phase;
		endcase
	end

	// actuators change only on phase entry
	always_comb begin
		nxt       = cur;
		nxt.phase = np;
		if (np != cur.phase) begin
			unique case (np)
				FP_FIRST:      nxt.valve = 1'b1;
				FP_END_FIRST:  nxt.valve = 1'b0;
				FP_SECOND:     nxt.pump2 = 1'b1;
				FP_END_SECOND: nxt.pump2 = 1'b0;
				default:       nxt.valve = cur.valve;
			endcase
		end
	end

endmodule

// File: rtl/tfd_drain_step.sv
// ----------------------------------------------------------------------------
// tfd_drain_step
// Next drain phase, drain pump level and saturating timers for one tick.
// ----------------------------------------------------------------------------
module tfd_drain_step (
	input  tfd_pkg::cfg_t        cfg,
	input  logic                 empty,
	input  tfd_pkg::fill_phase_t fill_phase,
	input  tfd_pkg::drain_st_t   cur,
	output tfd_pkg::drain_st_t   nxt
);
	import tfd_pkg::*;

	drain_phase_t np;
	logic         on_expired;
	logic         wait_expired;
	timer_t       on_t;
	timer_t       wait_t;
	logic         pump;

	assign on_expired   = CMP_W'(cur.on_timer) >= CMP_W'(cfg.drain_time_limit);
	assign wait_expired = CMP_W'(cur.wait_timer) >= CMP_W'(cfg.drain_wait_time);

	always_comb begin
		np = cur.phase;
		unique case (cur.phase)
			DP_IDLE:  if (!empty && fill_phase == FP_IDLE) np = DP_START;
			DP_START: np = DP_DRAIN;
			DP_DRAIN: if (empty || on_expired) np = DP_END;
			DP_END:   np = empty ? DP_IDLE : DP_WAIT;
			DP_WAIT:  if (wait_expired) np = DP_IDLE;
			default:  np = cur.phase;
		endcase
	end

	always_comb begin
		on_t   = cur.on_timer;
		wait_t = cur.wait_timer;
		pump   = cur.pump;
		if (np != cur.phase) begin
			unique case (np)
				DP_START: begin
					on_t = '0;
					pump = 1'b1;
				end
				DP_END: begin
					wait_t = '0;
					pump   = 1'b0;
				end
				default: pump = cur.pump;
			endcase
		end
		nxt.phase      = np;
		nxt.pump       = pump;
		nxt.on_timer   = sat_inc(on_t);
		nxt.wait_timer = sat_inc(wait_t);
	end

endmodule

// File: rtl/tank_fill_drain_sequencer.sv
// ----------------------------------------------------------------------------
// tank_fill_drain_sequencer
// Tank fill and drain sequencer: one sensor item in, one result item out.
// ----------------------------------------------------------------------------
// Each sensor item is one tick. It is captured in an input register, then the
// fill and drain steps update the phase, timer and actuator registers, and the
// updated state is presented as the result item. A new item is taken every
// cycle while results are consumed; throughput is one item per clock. The item
// passes through the input register and then the state registers before its
// result is valid. The result is held in the state registers until taken,
// which stalls the input register.
// Register writes are registered and are expected only while idle.
// ----------------------------------------------------------------------------
module tank_fill_drain_sequencer (
	input  logic      clk,
	input  logic      arst_n,
	tfd_in_if.sink    sensor,
	tfd_out_if.source result,
	tfd_cfg_if.sink   cfg
);
	import tfd_pkg::*;

	cfg_t      regs;
	levels_t   lvl_s1;
	logic      valid_s1;
	logic      res_valid_q;
	logic      advance;
	fill_st_t  fill_q;
	fill_st_t  fill_nxt;
	drain_st_t drain_q;
	drain_st_t drain_nxt;

	tfd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	tfd_fill_step u_fill (
		.auto_refill (regs.auto_refill),
		.lvl         (lvl_s1),
		.cur         (fill_q),
		.nxt         (fill_nxt)
	);

	tfd_drain_step u_drain (
		.cfg        (regs),
		.empty      (lvl_s1.empty),
		.fill_phase (fill_nxt.phase),
		.cur        (drain_q),
		.nxt        (drain_nxt)
	);

	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign sensor.ready = !valid_s1 || advance;

	always_ff @(posedge clk) begin
		if (sensor.valid && sensor.ready) begin
			lvl_s1.empty  <= sensor.level_empty;
			lvl_s1.middle <= sensor.level_middle;
			lvl_s1.full   <= sensor.level_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1           <= 1'b0;
			res_valid_q        <= 1'b0;
			fill_q.phase       <= FP_IDLE;
			fill_q.valve       <= 1'b0;
			fill_q.pump2       <= 1'b0;
			drain_q.phase      <= DP_IDLE;
			drain_q.on_timer   <= '0;
			drain_q.wait_timer <= '0;
			drain_q.pump       <= 1'b0;
		end else begin
			if (sensor.ready) begin
				valid_s1 <= sensor.valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
				fill_q      <= fill_nxt;
				drain_q     <= drain_nxt;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid           = res_valid_q;
	assign result.first_valve_on  = fill_q.valve;
	assign result.second_pump_on  = fill_q.pump2;
	assign result.drain_pump_on   = drain_q.pump;
	assign result.fill_phase_out  = fill_code(fill_q.phase);
	assign result.drain_phase_out = drain_code(drain_q.phase);

endmodule

// File: rtl/tfd_checker.sv
// ----------------------------------------------------------------------------
// tfd_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       valve,
	input logic       pump2,
	input logic       drain_pump,
	input logic [2:0] fill_code,
	input logic [2:0] drain_code
);
	import tfd_pkg::*;

	logic       stall;
	logic [8:0] payload;
	logic       fill_ok;
	logic       drain_ok;

	assign stall    = res_valid && !res_ready;
	assign payload  = {valve, pump2, drain_pump, fill_code, drain_code};
	assign fill_ok  = (valve == (fill_code == FC_FIRST)) && (pump2 == (fill_code == FC_SECOND));
	assign drain_ok = drain_pump == ((drain_code == DC_START) || (drain_code == DC_DRAIN));

	`ASSERT_NEXT(a_res_hold, clk, arst_n, stall, res_valid && $stable(payload))
	`ASSERT_IMPLIES(a_fill_act, clk, arst_n, res_valid, fill_ok)
	`ASSERT_IMPLIES(a_drain_act, clk, arst_n, res_valid, drain_ok)
	`ASSERT_ALWAYS(a_rst_quiet, clk, arst_n || !res_valid)

endmodule

bind tank_fill_drain_sequencer tfd_checker u_tfd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.valve      (result.first_valve_on),
	.pump2      (result.second_pump_on),
	.drain_pump (result.drain_pump_on),
	.fill_code  (result.fill_phase_out),
	.drain_code (result.drain_phase_out)
);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for tank_fill_drain_sequencer. A queue of sensor items feeds a
// bursty driver, a monitor with a changing stall pattern takes result items,
// and each one is checked against a tick-by-tick model of the fill and drain
// sequencers. Register settings are changed between phases while idle.
// ----------------------------------------------------------------------------
module tb;
	import tfd_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;

	// e, m, f
	localparam logic [2:0] DIRECTED_LEVELS [18] = '{
		3'b100, 3'b000, 3'b010, 3'b000, 3'b001, 3'b000, 3'b000, 3'b010, 3'b100,
		3'b100, 3'b111, 3'b110, 3'b101, 3'b011, 3'b001, 3'b000, 3'b000, 3'b100
	};

	typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_CYCLIC} rx_mode_t;

	typedef struct packed {
		logic       valve;
		logic       pump2;
		logic       drain_pump;
		logic [2:0] fill_code;
		logic [2:0] drain_code;
	} tank_out_t;

	logic clk;
	logic arst_n;

	tfd_in_if  sensor_ch();
	tfd_out_if result_ch();
	tfd_cfg_if cfg_ch();

	tank_fill_drain_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sensor (sensor_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// model state and settings
	logic             refill_on;
	logic [CFG_W-1:0] drain_limit;
	logic [CFG_W-1:0] drain_pause;
	logic [2:0]       fill_st;
	logic [2:0]       drain_st;
	timer_t           on_ticks;
	timer_t           wait_ticks;
	logic             valve_q;
	logic             pump2_q;
	logic             drain_pump_q;

	levels_t   sensor_items[$];
	tank_out_t due_outputs[$];
	int        mismatches;
	bit        taken;
	int        burst_left;
	int        gap_left;
	int        stall_left;
	int        stall_phase;
	rx_mode_t  stall_mode;
	int        tank_height;

	task automatic step_tank(input levels_t lv, output tank_out_t o);
		logic [2:0] nf;
		logic [2:0] nd;
		nf = fill_st;
		case (fill_st)
			FC_IDLE:       if (lv.empty && !lv.middle && !lv.full) nf = FC_FIRST;
			FC_FIRST:      if (lv.middle) nf = FC_END_FIRST;
			FC_END_FIRST:  nf = FC_SECOND;
			FC_SECOND:     if (lv.full) nf = FC_END_SECOND;
			FC_END_SECOND: nf = refill_on ? FC_IDLE : FC_DONE;
			default: ;
		endcase
		if (nf != fill_st) begin
			fill_st = nf;
			if (nf == FC_FIRST) valve_q = 1'b1;
			else if (nf == FC_END_FIRST) valve_q = 1'b0;
			else if (nf == FC_SECOND) pump2_q = 1'b1;
			else if (nf == FC_END_SECOND) pump2_q = 1'b0;
		end
		// drain sees the fill phase already updated
		nd = drain_st;
		case (drain_st)
			DC_IDLE:  if (!lv.empty && fill_st == FC_IDLE) nd = DC_START;
			DC_START: nd = DC_DRAIN;
			DC_DRAIN: if (lv.empty || on_ticks >= drain_limit) nd = DC_END;
			DC_END:   nd = lv.empty ? DC_IDLE : DC_WAIT;
			DC_WAIT:  if (wait_ticks >= drain_pause) nd = DC_IDLE;
			default: ;
		endcase
		if (nd != drain_st) begin
			drain_st = nd;
			if (nd == DC_START) begin
				on_ticks = '0;
				drain_pump_q = 1'b1;
			end else if (nd == DC_END) begin
				drain_pump_q = 1'b0;
				wait_ticks = '0;
			end
		end
		if (on_ticks != TIMER_MAX) on_ticks = on_ticks + 1'b1;
		if (wait_ticks != TIMER_MAX) wait_ticks = wait_ticks + 1'b1;
		o.valve = valve_q;
		o.pump2 = pump2_q;
		o.drain_pump = drain_pump_q;
		o.fill_code = fill_st;
		o.drain_code = drain_st;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_AUTO_REFILL: refill_on = val[0];
			REG_DRAIN_LIMIT: drain_limit = val;
			REG_DRAIN_WAIT:  drain_pause = val;
			default: ;
		endcase
	endtask

	task automatic settle();
		while (sensor_items.size() != 0 || sensor_ch.valid || due_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly a physical level that rises and falls, with some sensor noise
	task automatic queue_random(input int n);
		levels_t lv;
		int r;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				lv = levels_t'(3'($urandom_range(0, 7)));
			end else begin
				r = $urandom_range(0, 9);
				if (r >= 4 && r <= 6 && tank_height < 3) tank_height++;
				else if (r >= 7 && tank_height > 0) tank_height--;
				lv.empty = (tank_height == 0);
				lv.middle = (tank_height >= 2);
				lv.full = (tank_height == 3);
			end
			sensor_items.push_back(lv);
		end
	endtask

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		sensor_ch.valid = 1'b0;
		sensor_ch.level_empty = 1'b0;
		sensor_ch.level_middle = 1'b0;
		sensor_ch.level_full = 1'b0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_AUTO_REFILL;
		cfg_ch.data = '0;
		refill_on = RST_AUTO_REFILL;
		drain_limit = RST_DRAIN_LIMIT;
		drain_pause = RST_DRAIN_WAIT;
		fill_st = FC_IDLE;
		drain_st = DC_IDLE;
		on_ticks = '0;
		wait_ticks = '0;
		valve_q = 1'b0;
		pump2_q = 1'b0;
		drain_pump_q = 1'b0;
		mismatches = 0;
		taken = 1'b0;
		burst_left = 8;
		gap_left = 0;
		stall_left = 0;
		stall_phase = 0;
		stall_mode = RX_OPEN;
		tank_height = 0;
	end

	// sender: bursts with random gaps
	always @(negedge clk) begin : driver
		levels_t item;
		if (!arst_n) begin
			sensor_ch.valid <= 1'b0;
		end else if (!(sensor_ch.valid && !taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				sensor_ch.valid <= 1'b0;
			end else if (sensor_items.size() != 0) begin
				item = sensor_items.pop_front();
				sensor_ch.valid <= 1'b1;
				sensor_ch.level_empty <= item.empty;
				sensor_ch.level_middle <= item.middle;
				sensor_ch.level_full <= item.full;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				sensor_ch.valid <= 1'b0;
			end
		end
		taken = 1'b0;
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = rx_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 120);
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			RX_OPEN:  result_ch.ready <= 1'b1;
			RX_COIN:  result_ch.ready <= 1'($urandom_range(0, 1));
			RX_SLOW:  result_ch.ready <= ($urandom_range(0, 3) == 0);
			default:  result_ch.ready <= (stall_phase % 3 != 0);
		endcase
	end

	// check results first, then predict for the item taken at this edge
	always @(posedge clk) begin : monitor
		tank_out_t got;
		tank_out_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.valve = result_ch.first_valve_on;
			got.pump2 = result_ch.second_pump_on;
			got.drain_pump = result_ch.drain_pump_on;
			got.fill_code = result_ch.fill_phase_out;
			got.drain_code = result_ch.drain_phase_out;
			if (due_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: valve %b pump2 %b drain %b fill %0d drain %0d",
						got.valve, got.pump2, got.drain_pump, got.fill_code, got.drain_code);
			end else begin
				want = due_outputs.pop_front();
				if (got.valve !== want.valve || got.pump2 !== want.pump2 ||
					got.drain_pump !== want.drain_pump || got.fill_code !== want.fill_code ||
					got.drain_code !== want.drain_code) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result mismatch: expected valve %b pump2 %b drain %b fill %0d drain %0d",
							want.valve, want.pump2, want.drain_pump, want.fill_code,
							want.drain_code);
						$display("                 got valve %b pump2 %b drain %b fill %0d drain %0d",
							got.valve, got.pump2, got.drain_pump, got.fill_code,
							got.drain_code);
					end
				end
			end
		end
		if (arst_n && sensor_ch.valid && sensor_ch.ready) begin
			step_tank('{empty: sensor_ch.level_empty, middle: sensor_ch.level_middle,
				full: sensor_ch.level_full}, want);
			due_outputs.push_back(want);
			taken = 1'b1;
		end
	end

	initial begin : stimulus
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		foreach (DIRECTED_LEVELS[i])
			sensor_items.push_back(levels_t'(DIRECTED_LEVELS[i]));
		for (int ph = 1; ph <= 7; ph++) begin
			settle();
			case (ph)
				1: begin
					write_reg(REG_AUTO_REFILL, 16'hFFFF);
					write_reg(REG_DRAIN_LIMIT, 16'h0000);
					write_reg(REG_DRAIN_WAIT, 16'h0000);
				end
				2: begin
					write_reg(REG_DRAIN_LIMIT, 16'hFFFF);
					write_reg(REG_DRAIN_WAIT, 16'hFFFF);
				end
				7: begin
					// spare index is ignored; auto refill off leaves fill stuck in done
					write_reg(REG_SPARE, 16'($urandom));
					write_reg(REG_AUTO_REFILL, 16'hFFFE);
					write_reg(REG_DRAIN_LIMIT, 16'($urandom_range(0, 10)));
					write_reg(REG_DRAIN_WAIT, 16'($urandom_range(0, 10)));
				end
				default: begin
					write_reg(REG_DRAIN_LIMIT, ($urandom_range(0, 4) == 0) ?
						16'($urandom_range(0, 300)) : 16'($urandom_range(0, 12)));
					write_reg(REG_DRAIN_WAIT, ($urandom_range(0, 4) == 0) ?
						16'($urandom_range(0, 300)) : 16'($urandom_range(0, 12)));
				end
			endcase
			@(negedge clk);
			cfg_ch.valid <= 1'b0;
			@(posedge clk);
			queue_random((ph == 2 || ph == 7) ? 150 : 250);
		end
		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#4000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
